### rtl/actuated_traffic_light_controller_top_macros.svh
// ----------------------------------------------------------------------------
// atlc assertion macros
// shared concurrent assertion forms for the traffic controller
// ----------------------------------------------------------------------------
`ifndef ACTUATED_TRAFFIC_LIGHT_CONTROLLER_TOP_MACROS_SVH
`define ACTUATED_TRAFFIC_LIGHT_CONTROLLER_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ATLC_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define ATLC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/atlc_pkg.sv
// ----------------------------------------------------------------------------
// atlc_pkg
// types and constants of the actuated traffic light controller
// ----------------------------------------------------------------------------
`default_nettype none

package atlc_pkg;

    localparam int LIMIT_W = 16;
    localparam int OUT_COUNT_W = 16;

    // request kinds
    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_EMERGENCY = 2'd1,
        OP_CLEAR     = 2'd2
    } op_t;

    // signal phases
    typedef enum logic [2:0] {
        PH_NS_GREEN  = 3'd0,
        PH_NS_YELLOW = 3'd1,
        PH_EW_GREEN  = 3'd2,
        PH_EW_YELLOW = 3'd3,
        PH_EMERGENCY = 3'd4
    } phase_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIN_GREEN  = 3'd0,
        CFG_MID_GREEN  = 3'd1,
        CFG_HIGH_GREEN = 3'd2,
        CFG_MAX_GREEN  = 3'd3,
        CFG_YELLOW     = 3'd4,
        CFG_EMERGENCY  = 3'd5
    } cfg_idx_t;

    // lamp codes, bit 5 ns_red down to bit 0 ew_grn
    localparam logic [5:0] LAMPS_NSG_EWR = 6'h0C;
    localparam logic [5:0] LAMPS_NSY_EWR = 6'h14;
    localparam logic [5:0] LAMPS_NSR_EWG = 6'h21;
    localparam logic [5:0] LAMPS_NSR_EWY = 6'h22;
    localparam logic [5:0] LAMPS_ALL_RED = 6'h24;

    // register reset values
    localparam logic [LIMIT_W-1:0] RST_MIN_GREEN  = 16'd3000;
    localparam logic [LIMIT_W-1:0] RST_MID_GREEN  = 16'd5000;
    localparam logic [LIMIT_W-1:0] RST_HIGH_GREEN = 16'd7000;
    localparam logic [LIMIT_W-1:0] RST_MAX_GREEN  = 16'd10000;
    localparam logic [LIMIT_W-1:0] RST_YELLOW     = 16'd2000;
    localparam logic [LIMIT_W-1:0] RST_EMERGENCY  = 16'd15000;

    // vehicle count thresholds for green selection
    localparam int THR_MAX  = 10;
    localparam int THR_HIGH = 5;
    localparam int THR_MID  = 2;

    typedef struct packed {
        logic [LIMIT_W-1:0] min_green;
        logic [LIMIT_W-1:0] mid_green;
        logic [LIMIT_W-1:0] high_green;
        logic [LIMIT_W-1:0] max_green;
        logic [LIMIT_W-1:0] yellow;
        logic [LIMIT_W-1:0] emergency;
    } cfg_t;

    typedef struct packed {
        op_t  op;
        logic ew_det;
        logic ns_det;
    } item_t;

    // packed so that ns_red lands in bit 0
    typedef struct packed {
        logic [LIMIT_W-1:0]     green_time_ms;
        logic [OUT_COUNT_W-1:0] ew_vehicles;
        logic [OUT_COUNT_W-1:0] ns_vehicles;
        phase_t                 phase;
        logic                   ew_grn;
        logic                   ew_amber;
        logic                   ew_red;
        logic                   ns_grn;
        logic                   ns_amber;
        logic                   ns_red;
    } result_t;

endpackage

`default_nettype wire

### rtl/atlc_cfg_regs.sv
// ----------------------------------------------------------------------------
// atlc_cfg_regs
// timing registers written through the configuration channel
// ----------------------------------------------------------------------------
`default_nettype none

module atlc_cfg_regs import atlc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [LIMIT_W-1:0] cfg_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_GREEN:  cfg_next.min_green  = cfg_data;
                CFG_MID_GREEN:  cfg_next.mid_green  = cfg_data;
                CFG_HIGH_GREEN: cfg_next.high_green = cfg_data;
                CFG_MAX_GREEN:  cfg_next.max_green  = cfg_data;
                CFG_YELLOW:     cfg_next.yellow     = cfg_data;
                CFG_EMERGENCY:  cfg_next.emergency  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_green  <= RST_MIN_GREEN;
            cfg_reg.mid_green  <= RST_MID_GREEN;
            cfg_reg.high_green <= RST_HIGH_GREEN;
            cfg_reg.max_green  <= RST_MAX_GREEN;
            cfg_reg.yellow     <= RST_YELLOW;
            cfg_reg.emergency  <= RST_EMERGENCY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/atlc_in_stage.sv
// ----------------------------------------------------------------------------
// atlc_in_stage
// input register holding one request until the controller takes it
// ----------------------------------------------------------------------------
`default_nettype none

module atlc_in_stage import atlc_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // take a request when empty or when the held one moves on
    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### rtl/atlc_core.sv
// ----------------------------------------------------------------------------
// atlc_core
// phase sequencer, vehicle counters and timers, one request per advance
// ----------------------------------------------------------------------------
`default_nettype none

`include "actuated_traffic_light_controller_top_macros.svh"

module atlc_core import atlc_pkg::*; #(
    parameter int COUNT_WIDTH = 16,
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic advance,
    input  item_t     item,
    input  cfg_t      cfg,
    output result_t   result
);

    localparam int CMP_W = (TIMER_WIDTH > LIMIT_W) ? TIMER_WIDTH : LIMIT_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    phase_t                 phase_reg,     phase_next;
    logic [5:0]             lamp_bits_reg, lamp_bits_next;
    logic [TIMER_WIDTH-1:0] phase_el_reg,  phase_el_next;
    logic [TIMER_WIDTH-1:0] emerg_el_reg,  emerg_el_next;
    logic [LIMIT_W-1:0]     green_reg,     green_next;
    logic [COUNT_WIDTH-1:0] ns_count_reg,  ns_count_next;
    logic [COUNT_WIDTH-1:0] ew_count_reg,  ew_count_next;
    logic                   ns_seen_reg,   ns_seen_next;
    logic                   ew_seen_reg,   ew_seen_next;

    logic [TIMER_WIDTH-1:0] phase_el_inc;
    logic [TIMER_WIDTH-1:0] emerg_el_inc;
    logic                   exited;

    function automatic logic [TIMER_WIDTH-1:0] timer_inc(input logic [TIMER_WIDTH-1:0] t);
        return (t == TIMER_MAX) ? t : t + TIMER_WIDTH'(1);
    endfunction

    function automatic logic reached(input logic [TIMER_WIDTH-1:0] t,
                                     input logic [LIMIT_W-1:0] lim);
        return CMP_W'(t) >= CMP_W'(lim);
    endfunction

    function automatic logic [LIMIT_W-1:0] green_for(input logic [COUNT_WIDTH-1:0] cnt,
                                                     input cfg_t c);
        logic [LIMIT_W-1:0] g;
        if (cnt > COUNT_WIDTH'(THR_MAX)) begin
            g = c.max_green;
        end else if (cnt > COUNT_WIDTH'(THR_HIGH)) begin
            g = c.high_green;
        end else if (cnt > COUNT_WIDTH'(THR_MID)) begin
            g = c.mid_green;
        end else begin
            g = c.min_green;
        end
        return g;
    endfunction

    assign phase_el_inc = timer_inc(phase_el_reg);
    assign emerg_el_inc = timer_inc(emerg_el_reg);

    // next state for the request at the head of the input register
    always_comb begin
        phase_next     = phase_reg;
        lamp_bits_next = lamp_bits_reg;
        phase_el_next  = phase_el_reg;
        emerg_el_next  = emerg_el_reg;
        green_next     = green_reg;
        ns_count_next  = ns_count_reg;
        ew_count_next  = ew_count_reg;
        ns_seen_next   = ns_seen_reg;
        ew_seen_next   = ew_seen_reg;
        exited         = 1'b0;
        case (item.op)
            OP_TICK: begin
                // emergency timeout resumes at ns green
                if (phase_reg == PH_EMERGENCY) begin
                    emerg_el_next = emerg_el_inc;
                    if (reached(emerg_el_inc, cfg.emergency)) begin
                        phase_next     = PH_NS_GREEN;
                        lamp_bits_next = LAMPS_NSG_EWR;
                        phase_el_next  = '0;
                        exited         = 1'b1;
                    end
                end
                // rising sensor edges count vehicles
                ns_seen_next = item.ns_det;
                ew_seen_next = item.ew_det;
                if (item.ns_det && !ns_seen_reg && ns_count_reg != COUNT_MAX) begin
                    ns_count_next = ns_count_reg + COUNT_WIDTH'(1);
                end
                if (item.ew_det && !ew_seen_reg && ew_count_reg != COUNT_MAX) begin
                    ew_count_next = ew_count_reg + COUNT_WIDTH'(1);
                end
                // phase timer
                if (!exited && phase_reg != PH_EMERGENCY) begin
                    phase_el_next = phase_el_inc;
                    case (phase_reg)
                        PH_NS_GREEN: begin
                            if (reached(phase_el_inc, green_reg)) begin
                                phase_next     = PH_NS_YELLOW;
                                lamp_bits_next = LAMPS_NSY_EWR;
                                phase_el_next  = '0;
                            end
                        end
                        PH_NS_YELLOW: begin
                            if (reached(phase_el_inc, cfg.yellow)) begin
                                phase_next     = PH_EW_GREEN;
                                lamp_bits_next = LAMPS_NSR_EWG;
                                phase_el_next  = '0;
                                green_next     = green_for(ew_count_next, cfg);
                            end
                        end
                        PH_EW_GREEN: begin
                            if (reached(phase_el_inc, green_reg)) begin
                                phase_next     = PH_EW_YELLOW;
                                lamp_bits_next = LAMPS_NSR_EWY;
                                phase_el_next  = '0;
                            end
                        end
                        default: begin
                            if (reached(phase_el_inc, cfg.yellow)) begin
                                phase_next     = PH_NS_GREEN;
                                lamp_bits_next = LAMPS_NSG_EWR;
                                phase_el_next  = '0;
                                green_next     = green_for(ns_count_next, cfg);
                            end
                        end
                    endcase
                end
            end
            OP_EMERGENCY: begin
                phase_next     = PH_EMERGENCY;
                lamp_bits_next = LAMPS_ALL_RED;
                emerg_el_next  = '0;
            end
            OP_CLEAR: begin
                ns_count_next = '0;
                ew_count_next = '0;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_NS_GREEN;
            lamp_bits_reg <= LAMPS_NSG_EWR;
            phase_el_reg  <= '0;
            emerg_el_reg  <= '0;
            green_reg     <= RST_MIN_GREEN;
            ns_count_reg  <= '0;
            ew_count_reg  <= '0;
            ns_seen_reg   <= 1'b0;
            ew_seen_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            lamp_bits_reg <= lamp_bits_next;
            phase_el_reg  <= phase_el_next;
            emerg_el_reg  <= emerg_el_next;
            green_reg     <= green_next;
            ns_count_reg  <= ns_count_next;
            ew_count_reg  <= ew_count_next;
            ns_seen_reg   <= ns_seen_next;
            ew_seen_reg   <= ew_seen_next;
        end
    end

    // result fields follow the updated state
    always_comb begin
        result.ns_red        = lamp_bits_next[5];
        result.ns_amber      = lamp_bits_next[4];
        result.ns_grn        = lamp_bits_next[3];
        result.ew_red        = lamp_bits_next[2];
        result.ew_amber      = lamp_bits_next[1];
        result.ew_grn        = lamp_bits_next[0];
        result.phase         = phase_next;
        result.ns_vehicles   = OUT_COUNT_W'(ns_count_next);
        result.ew_vehicles   = OUT_COUNT_W'(ew_count_next);
        result.green_time_ms = green_next;
    end

    // checks
    `ATLC_ASSERT_NOW(a_emerg_all_red, aclk, aresetn, phase_reg == PH_EMERGENCY,
        lamp_bits_reg == LAMPS_ALL_RED, "emergency phase without all red lamps")
    `ATLC_ASSERT_NOW(a_one_lamp_each, aclk, aresetn, 1'b1,
        $onehot(lamp_bits_reg[5:3]) && $onehot(lamp_bits_reg[2:0]),
        "approach does not show exactly one lamp")
    `ATLC_ASSERT_NOW(a_one_green_side, aclk, aresetn, 1'b1,
        !(lamp_bits_reg[3] && lamp_bits_reg[0]), "both approaches green")
    `ATLC_ASSERT_NEXT(a_emerg_enter, aclk, aresetn, advance && item.op == OP_EMERGENCY,
        phase_reg == PH_EMERGENCY && emerg_el_reg == '0, "emergency request not taken")
    `ATLC_ASSERT_NEXT(a_clear_counts, aclk, aresetn, advance && item.op == OP_CLEAR,
        ns_count_reg == '0 && ew_count_reg == '0, "count clear request not taken")

endmodule

`default_nettype wire

### rtl/atlc_out_stage.sv
// ----------------------------------------------------------------------------
// atlc_out_stage
// result register toward the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module atlc_out_stage import atlc_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  result_t   result,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // valid stays until the result is taken or replaced
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

### rtl/actuated_traffic_light_controller_top.sv
// ----------------------------------------------------------------------------
// actuated_traffic_light_controller_top
// two-approach actuated traffic light controller with emergency override
// ----------------------------------------------------------------------------
//  channel   ports            carries
//  s_        tvalid/tready    tuser op, tdata sensor levels (one request each)
//  m_        tvalid/tready    tdata lamps, phase, counts, green time
//  cfg_      valid/ready      cfg_index, cfg_data timing register write
//
//  one request per cycle sustained while m_tready stays high; a request is held in the
//  input register and its result is registered in the result register toward m_.
//  the state update is a single pass of compares and increments between the
//  input register and the result register.
//  aresetn is synchronous, active low; it restores timings and the ns green phase.
//  m_tready low holds the result; s_tready then drops once the input register fills.
// ----------------------------------------------------------------------------
`default_nettype none

module actuated_traffic_light_controller_top import atlc_pkg::*; #(
    parameter int COUNT_WIDTH = 16,
    parameter int TIMER_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] ns_det, [1] ew_det, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [0] ns_red, [1] ns_amber, [2] ns_grn,
                                        // [3] ew_red, [4] ew_amber, [5] ew_grn,
                                        // [8:6] phase, [24:9] ns_vehicles,
                                        // [40:25] ew_vehicles, [56:41] green_time_ms
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int RES_W = $bits(result_t);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    out_valid;
    cfg_t    cfg;
    result_t result;
    result_t out_result;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    atlc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // unpack the request
    always_comb begin
        in_item.op     = op_t'(s_tuser);
        in_item.ns_det = s_tdata[0];
        in_item.ew_det = s_tdata[1];
    end

    // a held request moves on when the result register is free or draining
    assign advance = item_valid && (!out_valid || m_tready);

    atlc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    atlc_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    atlc_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result     (result),
        .out_valid  (out_valid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {{(64 - RES_W){1'b0}}, out_result};

endmodule

`default_nettype wire

### tb/sv/actuated_traffic_light_controller_top_tb.sv
// ----------------------------------------------------------------------------
// actuated traffic light controller testbench
// drives tick, emergency, count-clear and unused-op requests into the controller,
// predicts lamps, phase, vehicle counts and green time for every request,
// and compares each result field by field under random idling and stalls
// ----------------------------------------------------------------------------
`default_nettype none

module actuated_traffic_light_controller_top_tb;
    import atlc_pkg::*;

    // op code the block reports on without changing state
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [15:0] SAT_TOP = 16'hFFFF;
    // receiver hold-off length for the backpressure test
    localparam int HOLD_CYCLES = 200;
    // the longest quiet stretch of a correct run is the hold-off above;
    // random gaps stay far below it, so ten times that is a safe limit
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS = 40;
    // sensor pulses per approach in the edge burst
    localparam int EDGE_BURST = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    actuated_traffic_light_controller_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // signal plan model state
    logic [15:0] timing [6];
    phase_t      sig_phase;
    logic [5:0]  sig_lamps;
    logic [15:0] phase_ticks;
    logic [15:0] emerg_ticks;
    logic [15:0] green_ms;
    logic [15:0] ns_cars;
    logic [15:0] ew_cars;
    logic        ns_prev;
    logic        ew_prev;
    result_t     lamp_plan_q [$];

    // run bookkeeping
    bit          steady = 1'b0;
    bit          sink_hold = 1'b0;
    event        hold_start;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          n_ticks = 0;
    int          n_emerg = 0;
    int          n_clear = 0;
    int          n_unused = 0;
    int          n_checked = 0;
    int          phase_changes = 0;
    logic [15:0] peak_cars = '0;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == SAT_TOP) ? v : v + 16'd1;
    endfunction

    // green time picked from the count of the approach turning green
    function automatic logic [15:0] green_for_count(input logic [15:0] cars);
        if (cars > THR_MAX) return timing[CFG_MAX_GREEN];
        if (cars > THR_HIGH) return timing[CFG_HIGH_GREEN];
        if (cars > THR_MID) return timing[CFG_MID_GREEN];
        return timing[CFG_MIN_GREEN];
    endfunction

    task automatic reset_model();
        timing[CFG_MIN_GREEN]  = RST_MIN_GREEN;
        timing[CFG_MID_GREEN]  = RST_MID_GREEN;
        timing[CFG_HIGH_GREEN] = RST_HIGH_GREEN;
        timing[CFG_MAX_GREEN]  = RST_MAX_GREEN;
        timing[CFG_YELLOW]     = RST_YELLOW;
        timing[CFG_EMERGENCY]  = RST_EMERGENCY;
        sig_phase   = PH_NS_GREEN;
        sig_lamps   = LAMPS_NSG_EWR;
        phase_ticks = '0;
        emerg_ticks = '0;
        green_ms    = RST_MIN_GREEN;
        ns_cars     = '0;
        ew_cars     = '0;
        ns_prev     = 1'b0;
        ew_prev     = 1'b0;
    endtask

    task automatic enter_phase(input phase_t ph, input logic [5:0] lamps);
        sig_phase   = ph;
        sig_lamps   = lamps;
        phase_ticks = '0;
    endtask

    // advance the model by one accepted request and queue its result
    task automatic apply_request(input logic [1:0] op, input logic ns, input logic ew);
        result_t r;
        phase_t  was;
        logic    left_emerg;
        was = sig_phase;
        left_emerg = 1'b0;
        case (op)
            OP_TICK: begin
                n_ticks++;
                // emergency timer first, then sensors, then phase timer
                if (sig_phase == PH_EMERGENCY) begin
                    emerg_ticks = sat_inc(emerg_ticks);
                    if (emerg_ticks >= timing[CFG_EMERGENCY]) begin
                        enter_phase(PH_NS_GREEN, LAMPS_NSG_EWR);
                        left_emerg = 1'b1;
                    end
                end
                if (ns && !ns_prev) ns_cars = sat_inc(ns_cars);
                if (ew && !ew_prev) ew_cars = sat_inc(ew_cars);
                ns_prev = ns;
                ew_prev = ew;
                if (!left_emerg && sig_phase != PH_EMERGENCY) begin
                    phase_ticks = sat_inc(phase_ticks);
                    case (sig_phase)
                        PH_NS_GREEN: begin
                            if (phase_ticks >= green_ms)
                                enter_phase(PH_NS_YELLOW, LAMPS_NSY_EWR);
                        end
                        PH_NS_YELLOW: begin
                            if (phase_ticks >= timing[CFG_YELLOW]) begin
                                enter_phase(PH_EW_GREEN, LAMPS_NSR_EWG);
                                green_ms = green_for_count(ew_cars);
                            end
                        end
                        PH_EW_GREEN: begin
                            if (phase_ticks >= green_ms)
                                enter_phase(PH_EW_YELLOW, LAMPS_NSR_EWY);
                        end
                        default: begin
                            if (phase_ticks >= timing[CFG_YELLOW]) begin
                                enter_phase(PH_NS_GREEN, LAMPS_NSG_EWR);
                                green_ms = green_for_count(ns_cars);
                            end
                        end
                    endcase
                end
            end
            OP_EMERGENCY: begin
                n_emerg++;
                sig_phase   = PH_EMERGENCY;
                sig_lamps   = LAMPS_ALL_RED;
                emerg_ticks = '0;
            end
            OP_CLEAR: begin
                n_clear++;
                ns_cars = '0;
                ew_cars = '0;
            end
            default: n_unused++;
        endcase
        if (sig_phase != was) phase_changes++;
        if (ns_cars > peak_cars) peak_cars = ns_cars;
        if (ew_cars > peak_cars) peak_cars = ew_cars;
        r = '0;
        r.ns_red        = sig_lamps[5];
        r.ns_amber      = sig_lamps[4];
        r.ns_grn        = sig_lamps[3];
        r.ew_red        = sig_lamps[2];
        r.ew_amber      = sig_lamps[1];
        r.ew_grn        = sig_lamps[0];
        r.phase         = sig_phase;
        r.ns_vehicles   = ns_cars;
        r.ew_vehicles   = ew_cars;
        r.green_time_ms = green_ms;
        lamp_plan_q.push_back(r);
    endtask

    // offer one request, with random idle cycles ahead of it
    task automatic send_request(input logic [1:0] op, input logic ns, input logic ew);
        while (!steady && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, ew, ns};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_request(op, ns, ew);
    endtask

    // stop offering and wait until every queued result has come back
    task automatic settle_block(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (lamp_plan_q.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic program_timings(input logic [15:0] min_g, input logic [15:0] mid_g,
                                   input logic [15:0] high_g, input logic [15:0] max_g,
                                   input logic [15:0] yel, input logic [15:0] emg);
        logic [15:0] vals [6];
        vals[CFG_MIN_GREEN]  = min_g;
        vals[CFG_MID_GREEN]  = mid_g;
        vals[CFG_HIGH_GREEN] = high_g;
        vals[CFG_MAX_GREEN]  = max_g;
        vals[CFG_YELLOW]     = yel;
        vals[CFG_EMERGENCY]  = emg;
        settle_block(4);
        for (int i = CFG_MIN_GREEN; i <= CFG_EMERGENCY; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            timing[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int n_items);
        int         pick;
        logic [1:0] op;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (pick < 88) op = OP_TICK;
            else if (pick < 93) op = OP_EMERGENCY;
            else if (pick < 98) op = OP_CLEAR;
            else op = OP_UNUSED;
            send_request(op, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // reset timings: first green, sensor edges, unused op, clear keeps edge memory
    task automatic test_reset_values();
        send_request(OP_TICK, 1'b0, 1'b0);
        send_request(OP_UNUSED, 1'b1, 1'b1);
        send_request(OP_TICK, 1'b1, 1'b0);
        send_request(OP_TICK, 1'b1, 1'b1);
        send_request(OP_CLEAR, 1'b0, 1'b0);
        send_request(OP_TICK, 1'b1, 1'b1);
        send_request(OP_TICK, 1'b0, 1'b0);
    endtask

    // all red, counting during emergency, restart, exit to ns green
    task automatic test_emergency();
        program_timings(16'd2, 16'd3, 16'd4, 16'd5, 16'd1, 16'd2);
        send_request(OP_EMERGENCY, 1'b0, 1'b0);
        send_request(OP_TICK, 1'b1, 1'b0);
        send_request(OP_EMERGENCY, 1'b1, 1'b1);
        send_request(OP_TICK, 1'b0, 1'b0);
        send_request(OP_TICK, 1'b0, 1'b1);
        send_request(OP_TICK, 1'b0, 1'b0);
    endtask

    // let the current green run out, then walk the phases through eight phase changes
    task automatic test_phase_walk();
        int start;
        int i;
        start = phase_changes;
        i = 0;
        while (phase_changes < start + 8) begin
            send_request(OP_TICK, i[3], i[0]);
            i++;
        end
    endtask

    // back-to-back sensor edges lift both counts past every threshold
    task automatic test_count_edges();
        steady = 1'b1;
        send_request(OP_CLEAR, 1'b0, 1'b0);
        for (int i = 0; i < 2 * EDGE_BURST; i++)
            send_request(OP_TICK, ~i[0], ~i[0]);
        send_request(OP_CLEAR, 1'b0, 1'b0);
        steady = 1'b0;
    endtask

    // several timing sets, the extremes among them
    task automatic test_random_timings();
        program_timings(16'($urandom_range(12, 1)), 16'($urandom_range(12, 1)),
                        16'($urandom_range(12, 1)), 16'($urandom_range(12, 1)),
                        16'($urandom_range(6, 1)), 16'($urandom_range(8, 1)));
        random_traffic(200);
        program_timings(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        steady = 1'b1;
        random_traffic(200);
        steady = 1'b0;
        program_timings(16'd1, SAT_TOP, 16'd2, SAT_TOP, 16'd1, SAT_TOP);
        random_traffic(150);
        program_timings(16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)),
                        16'($urandom_range(20, 1)), 16'($urandom_range(20, 1)),
                        16'($urandom_range(4, 1)), 16'($urandom_range(10, 1)));
        random_traffic(250);
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        program_timings(16'd3, 16'd4, 16'd6, 16'd9, 16'd2, 16'd5);
        -> hold_start;
        steady = 1'b1;
        random_traffic(40);
        steady = 1'b0;
    endtask

    initial begin
        reset_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_emergency();
        test_phase_walk();
        test_count_edges();
        test_random_timings();
        test_backpressure();
        settle_block(DRAIN_CYCLES);
        $display("covered %0d requests: %0d ticks, %0d emergency, %0d count clears, %0d unused",
                 n_ticks + n_emerg + n_clear + n_unused, n_ticks, n_emerg, n_clear, n_unused);
        $display("%0d results checked, %0d phase changes, highest vehicle count %0d",
                 n_checked, phase_changes, peak_cars);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // long receiver hold-off, counted here
    always begin
        @(hold_start);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch at %0t, result %0d, %s: got %0h, expected %0h",
                     $time, n_checked, field, got, want);
        mismatch_count++;
    endtask

    // receiver ready and result check
    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (sink_hold) begin
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 25);
        end
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = result_t'(m_tdata[56:0]);
            if (lamp_plan_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                want = lamp_plan_q.pop_front();
                if (got.ns_red !== want.ns_red)
                    report_mismatch("ns_red", got.ns_red, want.ns_red);
                if (got.ns_amber !== want.ns_amber)
                    report_mismatch("ns_amber", got.ns_amber, want.ns_amber);
                if (got.ns_grn !== want.ns_grn)
                    report_mismatch("ns_grn", got.ns_grn, want.ns_grn);
                if (got.ew_red !== want.ew_red)
                    report_mismatch("ew_red", got.ew_red, want.ew_red);
                if (got.ew_amber !== want.ew_amber)
                    report_mismatch("ew_amber", got.ew_amber, want.ew_amber);
                if (got.ew_grn !== want.ew_grn)
                    report_mismatch("ew_grn", got.ew_grn, want.ew_grn);
                if (got.phase !== want.phase)
                    report_mismatch("phase", got.phase, want.phase);
                if (got.ns_vehicles !== want.ns_vehicles)
                    report_mismatch("ns_vehicles", got.ns_vehicles, want.ns_vehicles);
                if (got.ew_vehicles !== want.ew_vehicles)
                    report_mismatch("ew_vehicles", got.ew_vehicles, want.ew_vehicles);
                if (got.green_time_ms !== want.green_time_ms)
                    report_mismatch("green_time_ms", got.green_time_ms, want.green_time_ms);
                if (m_tdata[63:57] !== '0)
                    report_mismatch("tdata padding", m_tdata[63:57], '0);
            end
            n_checked++;
        end
    end

    // watchdog on cycles with no request, result or register write moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d results outstanding",
                     quiet_cycles, lamp_plan_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/atlc_pkg.sv
rtl/atlc_cfg_regs.sv
rtl/atlc_in_stage.sv
rtl/atlc_core.sv
rtl/atlc_out_stage.sv
rtl/actuated_traffic_light_controller_top.sv
tb/sv/actuated_traffic_light_controller_top_tb.sv
